@@ hdl/mprc_pkg.sv @@
// ----------------------------------------------------------------------------
// mprc_pkg
// Shared constants, types and the CRC-16 byte update for the position reply
// checker.
// ----------------------------------------------------------------------------
package mprc_pkg;

    // receive buffer depth, a frame ends when it holds this many bytes
    localparam int BUF_DEPTH = 16;
    // byte counter width, must hold BUF_DEPTH itself
    localparam int CNT_W     = $clog2(BUF_DEPTH + 1);

    // reply layout
    localparam int REPLY_LEN = 9;
    localparam int CRC_SPAN  = 7;
    localparam int POS_FIRST = 3;
    localparam int POS_LAST  = 6;
    localparam int CRC_LO    = 7;
    localparam int CRC_HI    = 8;

    // crc-16 constants
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    // result status codes
    typedef enum logic [1:0] {
        ST_IGNORED  = 2'd0,
        ST_UPDATED  = 2'd1,
        ST_CRC_FAIL = 2'd2
    } t_status;

    // result of one accepted byte
    typedef struct packed {
        logic        done;
        t_status     status;
        logic [31:0] position;
    } t_frame_result;

    // reflected crc-16 update over one byte, eight bit steps
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  data);
        logic [15:0] crc;
        crc = crc_in ^ {8'h00, data};
        for (int k = 0; k < 8; k++) begin
            if (crc[0]) begin
                crc = (crc >> 1) ^ CRC_POLY;
            end else begin
                crc = crc >> 1;
            end
        end
        return crc;
    endfunction

endpackage

@@ hdl/mprc_frame_tracker.sv @@
// ----------------------------------------------------------------------------
// mprc_frame_tracker
// Per-frame state: byte count, running CRC, received CRC, position bytes and
// the last good position. Produces the frame result on the closing byte.
// ----------------------------------------------------------------------------
module mprc_frame_tracker
    import mprc_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_accept,
    input  logic [7:0]    i_rx_byte,
    input  logic          i_frame_end,
    output t_frame_result o_result
);

    logic [CNT_W-1:0] r_byte_count, n_byte_count;
    logic [15:0]      r_crc_accum, n_crc_accum;
    logic [15:0]      r_received_crc, n_received_crc;
    logic [31:0]      r_data_word, n_data_word;
    logic [31:0]      r_good_position, n_good_position;

    logic [CNT_W-1:0] cnt_inc;
    logic [15:0]      crc_upd;
    logic [15:0]      rcv_upd;
    logic [31:0]      data_upd;
    logic             frame_done;
    t_status          status;

    // byte update and frame close decision
    always_comb begin
        cnt_inc  = r_byte_count + CNT_W'(1);
        crc_upd  = (r_byte_count < CNT_W'(CRC_SPAN)) ?
                   crc_byte(r_crc_accum, i_rx_byte) : r_crc_accum;
        data_upd = (r_byte_count >= CNT_W'(POS_FIRST) &&
                    r_byte_count <= CNT_W'(POS_LAST)) ?
                   {r_data_word[23:0], i_rx_byte} : r_data_word;
        rcv_upd  = r_received_crc;
        if (r_byte_count == CNT_W'(CRC_LO)) begin
            rcv_upd = {r_received_crc[15:8], i_rx_byte};
        end
        if (r_byte_count == CNT_W'(CRC_HI)) begin
            rcv_upd = {i_rx_byte, r_received_crc[7:0]};
        end
        frame_done = i_frame_end || (cnt_inc >= CNT_W'(BUF_DEPTH));

        status          = ST_IGNORED;
        n_good_position = r_good_position;
        if (cnt_inc == CNT_W'(REPLY_LEN)) begin
            if (rcv_upd == crc_upd) begin
                status = ST_UPDATED;
                if (i_accept && frame_done) begin
                    n_good_position = data_upd;
                end
            end else begin
                status = ST_CRC_FAIL;
            end
        end

        n_byte_count   = r_byte_count;
        n_crc_accum    = r_crc_accum;
        n_received_crc = r_received_crc;
        n_data_word    = r_data_word;
        if (i_accept) begin
            if (frame_done) begin
                n_byte_count   = '0;
                n_crc_accum    = CRC_INIT;
                n_received_crc = '0;
                n_data_word    = '0;
            end else begin
                n_byte_count   = cnt_inc;
                n_crc_accum    = crc_upd;
                n_received_crc = rcv_upd;
                n_data_word    = data_upd;
            end
        end

        o_result.done     = i_accept && frame_done;
        o_result.status   = status;
        o_result.position = (status == ST_UPDATED) ? data_upd : r_good_position;
    end

    // frame state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_count    <= '0;
            r_crc_accum     <= CRC_INIT;
            r_received_crc  <= '0;
            r_data_word     <= '0;
            r_good_position <= '0;
        end else begin
            r_byte_count    <= n_byte_count;
            r_crc_accum     <= n_crc_accum;
            r_received_crc  <= n_received_crc;
            r_data_word     <= n_data_word;
            r_good_position <= n_good_position;
        end
    end

    // counter never reaches the buffer depth between bytes
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_byte_count < CNT_W'(BUF_DEPTH))
        else $error("byte count reached buffer depth");

    // empty frame holds the crc seed
    a_crc_seed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_byte_count == '0) |-> (r_crc_accum == CRC_INIT))
        else $error("crc not reseeded at frame start");

    // no position byte gathered before byte three
    a_data_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_byte_count <= CNT_W'(POS_FIRST)) |-> (r_data_word == '0))
        else $error("data word not clear early in frame");

endmodule

@@ hdl/modbus_position_reply_checker.sv @@
// ----------------------------------------------------------------------------
// modbus_position_reply_checker
// Frames received reply bytes, checks the Modbus CRC-16 of 9-byte replies and
// reports the latest good 32-bit position once per frame.
// ----------------------------------------------------------------------------
// Bytes enter on the slave stream, one per cycle, with tlast marking the byte
// after which the line went idle; a frame also closes when it reaches
// BUF_DEPTH bytes. The CRC update is one unrolled byte step between the frame
// registers, and the frame result lands in an output register in the cycle after
// the closing byte. Input stalls only while that output register is full and the
// master side holds off. Results carry the status in tuser and the stored good
// position in tdata; on a CRC mismatch or a wrong length the previous good
// position is repeated.
module modbus_position_reply_checker
    import mprc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // slave stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] rx_byte
    input  logic        i_s_tlast,   // frame_end
    // master stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,   // [31:0] position
    output logic [1:0]  o_m_tuser    // [1:0] status
);

    logic          accept;
    t_frame_result result;

    logic          r_out_valid, n_out_valid;
    t_status       r_out_status, n_out_status;
    logic [31:0]   r_out_position, n_out_position;

    // take a byte whenever the result slot is free or draining
    assign o_s_tready = !r_out_valid || i_m_tready;
    assign accept     = i_s_tvalid && o_s_tready;

    mprc_frame_tracker u_tracker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_rx_byte   (i_s_tdata),
        .i_frame_end (i_s_tlast),
        .o_result    (result)
    );

    // result register next value
    always_comb begin
        n_out_valid    = r_out_valid;
        n_out_status   = r_out_status;
        n_out_position = r_out_position;
        if (result.done) begin
            n_out_valid    = 1'b1;
            n_out_status   = result.status;
            n_out_position = result.position;
        end else if (i_m_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_status   <= n_out_status;
        r_out_position <= n_out_position;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_position;
    assign o_m_tuser  = r_out_status;

    // full result slot under backpressure blocks input
    a_stall_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |-> !o_s_tready)
        else $error("input accepted while result stalled");

    // a closing byte always yields a result next cycle
    a_end_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready && i_s_tlast) |=> o_m_tvalid)
        else $error("frame end gave no result");

    // a new result only follows an accepted byte
    a_result_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> $past(i_s_tvalid && o_s_tready))
        else $error("result without accepted byte");

endmodule

@@ sim/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Testbench for modbus_position_reply_checker. Streams reply bytes into the
// slave side and tracks frames, CRC-16 and the stored position in its own
// model. Each result on the master side is compared with the oldest reply
// still due. Directed replies come first, then random frames: mostly
// well-formed replies with random content, plus corrupted replies and runs of
// random length that include buffer-full frames. Both sides idle at random in
// phases, and one long receiver hold-off backs the block up.
// ----------------------------------------------------------------------------
module tb;
    import mprc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_ITEMS      = 1450;
    localparam int PHASE_ITEMS  = 480;
    localparam int HOLD_AT      = 1150;
    localparam int HOLD_CYCLES  = 400;
    localparam int LIMIT_CYCLES = 200000;
    localparam int DRAIN_CYCLES = 16;

    // one byte on the slave stream
    typedef struct {
        logic [7:0] data;
        logic       last;
    } rx_item_t;

    // one frame result
    typedef struct {
        t_status     status;
        logic [31:0] position;
    } reply_t;

    logic        i_clk;
    logic        i_rst_n  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [7:0]  s_tdata  = 8'h00;
    logic        s_tlast  = 1'b0;
    logic        m_tready = 1'b0;
    logic        s_tready;
    logic        m_tvalid;
    logic [31:0] m_tdata;
    logic [1:0]  m_tuser;

    rx_item_t    pending_bytes[$];
    reply_t      replies_due[$];
    int          items_sent  = 0;
    int          total_items = 0;
    int          errors      = 0;
    int          cycle_cnt   = 0;
    int          hold_left   = 0;
    bit          hold_done   = 1'b0;

    // frame tracking state
    int          frame_len  = 0;
    logic [15:0] run_crc    = CRC_INIT;
    logic [15:0] rx_crc     = 16'h0000;
    logic [31:0] pos_word   = 32'h0;
    logic [31:0] good_pos   = 32'h0;

    modbus_position_reply_checker uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tlast  (s_tlast),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // crc-16, input bits folded into the feedback one at a time
    function automatic logic [15:0] crc16_add(input logic [15:0] acc,
                                              input logic [7:0]  b);
        logic [15:0] r;
        r = acc;
        for (int i = 0; i < 8; i++) begin
            if (r[0] ^ b[i]) begin
                r = (r >> 1) ^ CRC_POLY;
            end else begin
                r = r >> 1;
            end
        end
        return r;
    endfunction

    // advance the frame model by one accepted byte, queue a reply at frame end
    task automatic track_reply_byte(input logic [7:0] b, input logic last);
        reply_t r;
        int     idx;
        idx = frame_len;
        if (idx < CRC_SPAN) run_crc = crc16_add(run_crc, b);
        if (idx >= POS_FIRST && idx <= POS_LAST) pos_word = {pos_word[23:0], b};
        if (idx == CRC_LO) rx_crc[7:0] = b;
        if (idx == CRC_HI) rx_crc[15:8] = b;
        frame_len = idx + 1;
        if (last || frame_len >= BUF_DEPTH) begin
            if (frame_len == REPLY_LEN) begin
                if (rx_crc == run_crc) begin
                    good_pos = pos_word;
                    r.status = ST_UPDATED;
                end else begin
                    r.status = ST_CRC_FAIL;
                end
            end else begin
                r.status = ST_IGNORED;
            end
            r.position = good_pos;
            replies_due.push_back(r);
            frame_len = 0;
            run_crc   = CRC_INIT;
            rx_crc    = 16'h0000;
            pos_word  = 32'h0;
        end
    endtask

    // queue a 9-byte reply, optionally with one bit flipped somewhere
    task automatic add_reply(input logic [7:0] addr, input logic [7:0] func,
                             input logic [7:0] cnt, input logic [31:0] pos,
                             input bit corrupt);
        logic [7:0]  bytes[REPLY_LEN];
        logic [15:0] crc;
        rx_item_t    it;
        int          k;
        bytes[0] = addr;
        bytes[1] = func;
        bytes[2] = cnt;
        bytes[3] = pos[31:24];
        bytes[4] = pos[23:16];
        bytes[5] = pos[15:8];
        bytes[6] = pos[7:0];
        crc = CRC_INIT;
        for (int i = 0; i < CRC_SPAN; i++) crc = crc16_add(crc, bytes[i]);
        bytes[CRC_LO] = crc[7:0];
        bytes[CRC_HI] = crc[15:8];
        if (corrupt) begin
            k = $urandom_range(REPLY_LEN - 1);
            bytes[k][$urandom_range(7)] ^= 1'b1;
        end
        for (int i = 0; i < REPLY_LEN; i++) begin
            it.data = bytes[i];
            it.last = (i == REPLY_LEN - 1);
            pending_bytes.push_back(it);
        end
    endtask

    // queue a run of random bytes, tlast only on the final one if asked
    task automatic add_run(input int len, input bit last_at_end);
        rx_item_t it;
        for (int i = 0; i < len; i++) begin
            it.data = 8'($urandom);
            it.last = last_at_end && (i == len - 1);
            pending_bytes.push_back(it);
        end
    endtask

    function automatic logic [31:0] pick_position();
        case ($urandom_range(7))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // idle percentage for the current phase, sender or receiver side
    function automatic int idle_pct(input bit sender);
        if (items_sent < PHASE_ITEMS) return sender ? 34 : 65;
        if (items_sent < 2 * PHASE_ITEMS) return sender ? 65 : 34;
        return 0;
    endfunction

    // stimulus, reset and end of run
    initial begin
        int  pick;
        int  len;
        bit  last;

        // directed: extreme position, corrupted reply, single-byte frame
        add_reply(8'hFF, 8'h00, 8'hFF, 32'h8000_0000, 1'b0);
        add_reply(8'h00, 8'hFF, 8'h00, 32'h7FFF_FFFF, 1'b1);
        add_run(1, 1'b1);

        // random frames
        while (pending_bytes.size() < N_ITEMS) begin
            pick = $urandom_range(99);
            if (pick < 60) begin
                add_reply(8'($urandom), 8'($urandom), 8'($urandom), pick_position(), 1'b0);
            end else if (pick < 75) begin
                add_reply(8'($urandom), 8'($urandom), 8'($urandom), pick_position(), 1'b1);
            end else begin
                len  = $urandom_range(BUF_DEPTH, 1);
                last = (len < BUF_DEPTH) ? ($urandom_range(9) != 0)
                                         : 1'($urandom_range(1));
                add_run(len, last);
            end
        end
        total_items = pending_bytes.size();

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (items_sent != total_items || replies_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (replies_due.size() != 0) begin
            $display("%0t: %0d replies never arrived", $time, replies_due.size());
            errors++;
        end
        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // byte driver
    always @(posedge i_clk) begin : drive
        rx_item_t nxt;
        if (i_rst_n) begin
            if (s_tvalid && s_tready) begin
                track_reply_byte(s_tdata, s_tlast);
                items_sent <= items_sent + 1;
            end
            if (!s_tvalid || s_tready) begin
                if (pending_bytes.size() != 0 && $urandom_range(99) >= idle_pct(1'b1)) begin
                    nxt = pending_bytes.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= nxt.data;
                    s_tlast  <= nxt.last;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // result side ready, with one long hold-off once idling has stopped
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else if (!hold_done && items_sent >= HOLD_AT) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= idle_pct(1'b0));
        end
    end

    // result monitor
    always @(posedge i_clk) begin : watch
        reply_t exp_r;
        if (i_rst_n && m_tvalid && m_tready) begin
            if (replies_due.size() == 0) begin
                $display("%0t: unexpected item, status %0d position %h",
                         $time, m_tuser, m_tdata);
                errors++;
            end else begin
                exp_r = replies_due.pop_front();
                if (m_tuser !== exp_r.status) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, exp_r.status, m_tuser);
                    errors++;
                end
                if (m_tdata !== exp_r.position) begin
                    $display("%0t: position expected %h actual %h",
                             $time, exp_r.position, m_tdata);
                    errors++;
                end
            end
        end
    end

    // timeout
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= LIMIT_CYCLES) begin
            $display("FAILURE");
            $finish;
        end
    end

endmodule
